// ===== rtl/bsc_pkg.sv =====
package bsc_pkg;

  localparam int unsigned MaxRes = 8;

  localparam logic [1:0] BASE16 = 2'd0;
  localparam logic [1:0] BASE32 = 2'd1;
  localparam logic [1:0] BASE64 = 2'd2;

  localparam logic [1:0] RegDirection     = 2'd0;
  localparam logic [1:0] RegBaseSelect    = 2'd1;
  localparam logic [1:0] RegPaddingEnable = 2'd2;
  localparam logic [1:0] RegAltAlphabet   = 2'd3;

  localparam logic [7:0] PadChar = 8'h3D;

  typedef struct packed {
    logic [7:0] data;
    logic       has_data;
    logic       last;
    logic       bad;
  } res_t;

  typedef struct packed {
    logic [7:0][7:0] symbuf;
    logic [4:0]      hold;
    logic [2:0]      hcnt;
    logic [2:0]      gpos;
    logic            discard;
  } st_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } sym_t;

  function automatic logic [1:0] kind(logic [1:0] sel);
    logic [1:0] k;
    if (sel == BASE16) begin
      k = BASE16;
    end else if (sel == BASE32) begin
      k = BASE32;
    end else begin
      k = BASE64;
    end
    return k;
  endfunction

  function automatic logic [2:0] b32_take(logic [3:0] pads);
    logic [2:0] t;
    case (pads)
      4'd0:    t = 3'd5;
      4'd1:    t = 3'd4;
      4'd3:    t = 3'd3;
      4'd4:    t = 3'd2;
      4'd6:    t = 3'd1;
      default: t = 3'd0;
    endcase
    return t;
  endfunction

  function automatic logic [2:0] b64_take(logic [3:0] pads);
    logic [2:0] t;
    case (pads)
      4'd0:    t = 3'd6;
      4'd1:    t = 3'd5;
      4'd2:    t = 3'd4;
      4'd4:    t = 3'd3;
      4'd5:    t = 3'd2;
      4'd6:    t = 3'd1;
      default: t = 3'd0;
    endcase
    return t;
  endfunction

  function automatic logic [7:0] to_symbol(logic [1:0] k, logic alt, logic [5:0] v);
    logic [7:0] v8;
    logic [7:0] r;
    v8 = {2'b00, v};
    if (k == BASE16 || (k == BASE32 && alt)) begin
      v8 = {3'b000, v[4:0]};
      r  = (v8 < 8'd10) ? 8'h30 + v8 : 8'h37 + v8;
    end else if (k == BASE32) begin
      v8 = {3'b000, v[4:0]};
      r  = (v8 < 8'd26) ? 8'h41 + v8 : 8'h18 + v8;
    end else if (v8 < 8'd26) begin
      r = 8'h41 + v8;
    end else if (v8 < 8'd52) begin
      r = 8'h47 + v8;
    end else if (v8 < 8'd62) begin
      r = v8 - 8'd4;
    end else if (v8 == 8'd62) begin
      r = alt ? 8'h2D : 8'h2B;
    end else begin
      r = alt ? 8'h5F : 8'h2F;
    end
    return r;
  endfunction

  function automatic sym_t from_symbol(logic [1:0] k, logic alt, logic [7:0] c);
    sym_t       s;
    logic [7:0] d;
    s = '0;
    d = '0;
    if (k == BASE16 || (k == BASE32 && alt)) begin
      if (c >= 8'h30 && c <= 8'h39) begin
        s.ok = 1'b1;
        d    = c - 8'h30;
      end else if (c >= 8'h41 && c <= ((k == BASE16) ? 8'h46 : 8'h56)) begin
        s.ok = 1'b1;
        d    = c - 8'h37;
      end
    end else if (k == BASE32) begin
      if (c >= 8'h41 && c <= 8'h5A) begin
        s.ok = 1'b1;
        d    = c - 8'h41;
      end else if (c >= 8'h32 && c <= 8'h37) begin
        s.ok = 1'b1;
        d    = c - 8'h18;
      end
    end else begin
      if (c >= 8'h41 && c <= 8'h5A) begin
        s.ok = 1'b1;
        d    = c - 8'h41;
      end else if (c >= 8'h61 && c <= 8'h7A) begin
        s.ok = 1'b1;
        d    = c - 8'h47;
      end else if (c >= 8'h30 && c <= 8'h39) begin
        s.ok = 1'b1;
        d    = c + 8'd4;
      end else if (c == (alt ? 8'h2D : 8'h2B)) begin
        s.ok = 1'b1;
        d    = 8'd62;
      end else if (c == (alt ? 8'h5F : 8'h2F)) begin
        s.ok = 1'b1;
        d    = 8'd63;
      end
    end
    s.val = d[5:0];
    return s;
  endfunction

endpackage

// ===== rtl/bsc_step.sv =====
module bsc_step (
  input  logic                                  dir_i,
  input  logic [1:0]                            kind_i,
  input  logic                                  pad_en_i,
  input  logic                                  alt_i,
  input  bsc_pkg::st_t                          st_i,
  input  logic [7:0]                            byte_i,
  input  logic                                  last_i,
  output bsc_pkg::st_t                          st_o,
  output bsc_pkg::res_t [bsc_pkg::MaxRes-1:0]   res_o,
  output logic [3:0]                            cnt_o
);

  logic [12:0]          bits;
  logic [3:0]           ecnt;
  logic [3:0]           w;
  logic [5:0]           mask;
  logic                 two;
  logic [3:0]           rem;
  logic [12:0]          sh0;
  logic [12:0]          sh1;
  logic [15:0]          tail16;
  logic [5:0]           sv [3];
  logic [3:0]           nsym;
  logic [2:0]           gsum;
  logic [3:0]           npad;
  logic [3:0]           total;

  logic [7:0]           sym [8];
  bsc_pkg::sym_t        dv [8];
  logic [3:0]           gcnt;
  logic [2:0]           pairs;
  logic                 err;
  logic                 present;
  logic [5:0]           v;
  logic [3:0]           dpads;
  logic [39:0]          acc32;
  logic [47:0]          acc64;
  logic [7:0]           dec [6];
  logic [2:0]           take;

  always_comb begin
    st_o  = st_i;
    res_o = '0;
    cnt_o = '0;

    bits   = {st_i.hold, byte_i};
    ecnt   = {1'b0, st_i.hcnt} + 4'd8;
    w      = (kind_i == bsc_pkg::BASE32) ? 4'd5 : 4'd6;
    mask   = (kind_i == bsc_pkg::BASE32) ? 6'h1F : 6'h3F;
    two    = (ecnt >= {w[2:0], 1'b0});
    rem    = two ? ecnt - {w[2:0], 1'b0} : ecnt - w;
    sh0    = bits >> (ecnt - w);
    sh1    = bits >> rem;
    tail16 = {3'b000, bits} << (w - rem);
    sv[0]  = sh0[5:0] & mask;
    sv[2]  = tail16[5:0] & mask;
    sv[1]  = two ? (sh1[5:0] & mask) : sv[2];
    nsym   = (two ? 4'd2 : 4'd1) + {3'b000, last_i && rem != 4'd0};
    gsum   = st_i.gpos + nsym[2:0];
    npad   = '0;
    if (last_i && pad_en_i) begin
      npad = (kind_i == bsc_pkg::BASE32) ? {1'b0, 3'd0 - gsum} : {2'b00, 2'd0 - gsum[1:0]};
    end
    total = ((nsym + npad) > 4'd8) ? 4'd8 : nsym + npad;

    for (int i = 0; i < 8; i++) begin
      sym[i] = (st_i.gpos == 3'(i)) ? byte_i : st_i.symbuf[i];
      dv[i]  = bsc_pkg::from_symbol(kind_i, alt_i, sym[i]);
    end
    gcnt  = {1'b0, st_i.gpos} + 4'd1;
    pairs = gcnt[3:1];
    err   = 1'b0;
    dpads = '0;
    acc32 = '0;
    acc64 = '0;
    present = 1'b0;
    v = '0;
    for (int i = 0; i < 8; i++) begin
      present = (4'(i) < gcnt) && (sym[i] != bsc_pkg::PadChar);
      if (present && !dv[i].ok) begin
        err = 1'b1;
      end
      if (!present) begin
        dpads = dpads + 4'd1;
      end
      v = present ? dv[i].val : 6'd0;
      acc32[39-5*i -: 5] = v[4:0];
      acc64[47-6*i -: 6] = v;
    end
    for (int j = 0; j < 6; j++) begin
      dec[j] = (kind_i == bsc_pkg::BASE32) ?
               ((j < 5) ? acc32[39-8*(j%5) -: 8] : 8'h00) : acc64[47-8*j -: 8];
    end
    take = (kind_i == bsc_pkg::BASE32) ? bsc_pkg::b32_take(dpads) : bsc_pkg::b64_take(dpads);
    if (kind_i == bsc_pkg::BASE16) begin
      err = 1'b0;
      for (int i = 0; i < 4; i++) begin
        if (3'(i) < pairs && (!dv[2*i].ok || !dv[2*i+1].ok)) begin
          err = 1'b1;
        end
        dec[i] = {dv[2*i].val[3:0], dv[2*i+1].val[3:0]};
      end
      take = pairs;
    end

    if (!dir_i) begin
      if (kind_i == bsc_pkg::BASE16) begin
        res_o[0] = '{data: bsc_pkg::to_symbol(kind_i, alt_i, {2'b00, byte_i[7:4]}),
                     has_data: 1'b1, last: 1'b0, bad: 1'b0};
        res_o[1] = '{data: bsc_pkg::to_symbol(kind_i, alt_i, {2'b00, byte_i[3:0]}),
                     has_data: 1'b1, last: 1'b0, bad: 1'b0};
        cnt_o    = 4'd2;
      end else begin
        for (int i = 0; i < 8; i++) begin
          if (4'(i) < nsym && i < 3) begin
            res_o[i] = '{data: bsc_pkg::to_symbol(kind_i, alt_i, sv[i%3]),
                         has_data: 1'b1, last: 1'b0, bad: 1'b0};
          end else if (4'(i) < total) begin
            res_o[i] = '{data: bsc_pkg::PadChar, has_data: 1'b1, last: 1'b0, bad: 1'b0};
          end
        end
        cnt_o      = total;
        st_o.hold  = bits[4:0] & ~(5'h1F << rem);
        st_o.hcnt  = rem[2:0];
        st_o.gpos  = (kind_i == bsc_pkg::BASE32) ? gsum : {1'b0, gsum[1:0]};
      end
      if (last_i) begin
        for (int i = 0; i < 8; i++) begin
          if (4'(i) == cnt_o - 4'd1) begin
            res_o[i].last = 1'b1;
          end
        end
        st_o = '0;
      end
    end else if (st_i.discard) begin
      if (last_i) begin
        st_o = '0;
      end
    end else begin
      st_o.symbuf[st_i.gpos] = byte_i;
      if (gcnt < 4'd8 && !last_i) begin
        st_o.gpos = gcnt[2:0];
      end else if (err) begin
        res_o[0]     = '{data: 8'h00, has_data: 1'b0, last: 1'b1, bad: 1'b1};
        cnt_o        = 4'd1;
        st_o         = '0;
        st_o.discard = !last_i;
      end else begin
        for (int j = 0; j < 6; j++) begin
          if (3'(j) < take) begin
            res_o[j] = '{data: dec[j], has_data: 1'b1, last: 1'b0, bad: 1'b0};
          end
        end
        cnt_o     = {1'b0, take};
        st_o.gpos = '0;
        if (last_i) begin
          if (take == 3'd0) begin
            res_o[0] = '{data: 8'h00, has_data: 1'b0, last: 1'b1, bad: 1'b0};
            cnt_o    = 4'd1;
          end else begin
            for (int j = 0; j < 6; j++) begin
              if (3'(j) == take - 3'd1) begin
                res_o[j].last = 1'b1;
              end
            end
          end
          st_o = '0;
        end
      end
    end
  end

endmodule

// ===== rtl/base16_32_64_stream_codec_top.sv =====
// Base16 / Base32 / Base64 stream codec.
// Input stream (s_axis_*): one byte per item, tlast closes the stream. When
// encoding the byte is raw data, when decoding it is an ASCII character.
// Output stream (m_axis_*): one symbol or decoded byte per item; tuser[0]
// flags valid data, tuser[1] flags an illegal character (error item, always
// with tlast). A stream ends with exactly one tlast item.
// Config port (cfg_*): register index 0 direction, 1 base select, 2 padding
// enable, 3 alternate alphabet. Always ready. Each write restarts the stream
// state; write only while no items are in flight.
// The first result of an item passes through the input register and then
// the result burst register before it is presented on the output.
// Each item produces up to 8 results, held in the single output register,
// which drains its result burst one per cycle while the receiver is ready.
// Base16 encoding produces two symbols per byte.
// The input register and the result burst register decouple the two sides:
// a new item is taken while the previous burst drains. When the receiver
// stalls, the burst holds and the input side stops after one buffered item.
// Reset: config returns to encode, Base64, padding on, standard alphabet;
// all stream state and buffered items are cleared.
module base16_32_64_stream_codec_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic [1:0] m_axis_tuser,   // [0] has_data, [1] bad_char
  output logic       m_axis_tlast,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [1:0] cfg_data_i
);

  logic                                dir_q;
  logic [1:0]                          base_q;
  logic                                pad_en_q;
  logic                                alt_q;
  logic                                in_valid_q;
  logic [7:0]                          in_byte_q;
  logic                                in_last_q;
  bsc_pkg::st_t                        st_q;
  bsc_pkg::st_t                        st_d;
  bsc_pkg::res_t [bsc_pkg::MaxRes-1:0] ent_q;
  bsc_pkg::res_t [bsc_pkg::MaxRes-1:0] ent_d;
  logic [3:0]                          cnt_q;
  logic [3:0]                          cnt_d;
  logic                                burst_free;
  logic                                load;
  logic                                pop;
  logic                                cfg_wr;
  logic [1:0]                          kind;

  assign kind        = bsc_pkg::kind(base_q);
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  assign pop         = (cnt_q != 4'd0) && m_axis_tready;
  assign burst_free  = (cnt_q == 4'd0) || (cnt_q == 4'd1 && m_axis_tready);
  assign load        = in_valid_q && burst_free;
  assign s_axis_tready = !in_valid_q || load;

  assign m_axis_tvalid = (cnt_q != 4'd0);
  assign m_axis_tdata  = ent_q[0].data;
  assign m_axis_tuser  = {ent_q[0].bad, ent_q[0].has_data};
  assign m_axis_tlast  = ent_q[0].last;

  bsc_step u_step (
    .dir_i    (dir_q),
    .kind_i   (kind),
    .pad_en_i (pad_en_q),
    .alt_i    (alt_q),
    .st_i     (st_q),
    .byte_i   (in_byte_q),
    .last_i   (in_last_q),
    .st_o     (st_d),
    .res_o    (ent_d),
    .cnt_o    (cnt_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q      <= 1'b0;
      base_q     <= bsc_pkg::BASE64;
      pad_en_q   <= 1'b1;
      alt_q      <= 1'b0;
      in_valid_q <= 1'b0;
      st_q       <= '0;
      cnt_q      <= '0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_index_i)
          bsc_pkg::RegDirection:     dir_q    <= cfg_data_i[0];
          bsc_pkg::RegBaseSelect:    base_q   <= cfg_data_i;
          bsc_pkg::RegPaddingEnable: pad_en_q <= cfg_data_i[0];
          bsc_pkg::RegAltAlphabet:   alt_q    <= cfg_data_i[0];
          default:                   dir_q    <= dir_q;
        endcase
        st_q <= '0;
      end else if (load) begin
        st_q <= st_d;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        in_valid_q <= 1'b1;
      end else if (load) begin
        in_valid_q <= 1'b0;
      end
      if (load) begin
        cnt_q <= cnt_d;
      end else if (pop) begin
        cnt_q <= cnt_q - 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
    if (load) begin
      ent_q <= ent_d;
    end else if (pop) begin
      for (int i = 0; i < bsc_pkg::MaxRes - 1; i++) begin
        ent_q[i] <= ent_q[i+1];
      end
    end
  end

  a_discard_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.discard |-> dir_q)
    else $error("discard set while encoding");

  a_burst_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 4'd8)
    else $error("result burst too long");

  a_bad_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast && !m_axis_tuser[0])
    else $error("error item malformed");

  a_encode_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !dir_q |-> m_axis_tuser[0])
    else $error("encode item without data");

  a_hold_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.hcnt <= 3'd5)
    else $error("held bit count out of range");

endmodule

// ===== dv/tb_base16_32_64_stream_codec_top.sv =====
`timescale 1ns / 1ps

module tb_base16_32_64_stream_codec_top;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } in_item_t;

  logic       clk_i;
  logic       rst_ni;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;
  logic       s_axis_tlast;
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic       m_axis_tlast;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [1:0] cfg_index_i;
  logic [1:0] cfg_data_i;

  base16_32_64_stream_codec_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // codec model state
  logic       cfg_dir  = 1'b0;
  logic [1:0] cfg_base = bsc_pkg::BASE64;
  logic       cfg_pad  = 1'b1;
  logic       cfg_alt  = 1'b0;
  logic [11:0] bits_held;
  int          nbits_held;
  int          grp_pos;
  logic [7:0]  char_grp [8];
  logic [7:0]  grp_bytes [8];
  bit          discard;

  in_item_t      in_items_q [$];
  bsc_pkg::res_t burst_q [$];
  bsc_pkg::res_t expected_out_q [$];

  int  n_queued;
  int  n_taken;
  int  err_cnt;
  bit  in_fire;
  int  gap_left;
  bit  gaps_on;
  bit  rx_stalls;
  bit  hold_req;
  int  rx_wait;

  function automatic logic [1:0] active_base();
    if (cfg_base == bsc_pkg::BASE16) return bsc_pkg::BASE16;
    if (cfg_base == bsc_pkg::BASE32) return bsc_pkg::BASE32;
    return bsc_pkg::BASE64;
  endfunction

  function automatic string alphabet();
    string s;
    case (active_base())
      bsc_pkg::BASE16: s = "0123456789ABCDEF";
      bsc_pkg::BASE32: s = cfg_alt ? "0123456789ABCDEFGHIJKLMNOPQRSTUV"
                                   : "ABCDEFGHIJKLMNOPQRSTUVWXYZ234567";
      default: begin
        s = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789";
        s = cfg_alt ? {s, "-_"} : {s, "+/"};
      end
    endcase
    return s;
  endfunction

  function automatic int value_of(logic [7:0] c);
    string a;
    a = alphabet();
    for (int i = 0; i < a.len(); i++) begin
      if (a[i] == c) return i;
    end
    return -1;
  endfunction

  function automatic int bytes_for_pads(int pads);
    int b32_n [7] = '{5, 4, 0, 3, 2, 0, 1};
    int b64_n [7] = '{6, 5, 4, 0, 3, 2, 1};
    if (pads > 6) return 0;
    return (active_base() == bsc_pkg::BASE32) ? b32_n[pads] : b64_n[pads];
  endfunction

  function automatic void restart_stream();
    bits_held  = '0;
    nbits_held = 0;
    grp_pos    = 0;
    discard    = 1'b0;
    foreach (char_grp[i]) char_grp[i] = '0;
  endfunction

  function automatic void add_out(logic [7:0] d, logic has, logic last, logic bad);
    bsc_pkg::res_t r;
    r.data     = d;
    r.has_data = has;
    r.last     = last;
    r.bad      = bad;
    if (burst_q.size() < bsc_pkg::MaxRes) burst_q.push_back(r);
  endfunction

  function automatic void mark_last();
    bsc_pkg::res_t r;
    r = burst_q.pop_back();
    r.last = 1'b1;
    burst_q.push_back(r);
  endfunction

  function automatic void encode_byte(logic [7:0] b, logic last);
    string a;
    int w, glen, mask, bits, cnt;
    a = alphabet();
    if (active_base() == bsc_pkg::BASE16) begin
      add_out(a[b[7:4]], 1'b1, 1'b0, 1'b0);
      add_out(a[b[3:0]], 1'b1, 1'b0, 1'b0);
    end else begin
      w    = (active_base() == bsc_pkg::BASE32) ? 5 : 6;
      glen = (active_base() == bsc_pkg::BASE32) ? 8 : 4;
      mask = (1 << w) - 1;
      bits = (int'(bits_held) << 8) | int'(b);
      cnt  = nbits_held + 8;
      while (cnt >= w) begin
        cnt -= w;
        add_out(a[(bits >> cnt) & mask], 1'b1, 1'b0, 1'b0);
        grp_pos = (grp_pos + 1) % glen;
      end
      bits &= (1 << cnt) - 1;
      if (last) begin
        if (cnt > 0) begin
          add_out(a[(bits << (w - cnt)) & mask], 1'b1, 1'b0, 1'b0);
          grp_pos = (grp_pos + 1) % glen;
        end
        if (cfg_pad) begin
          while (grp_pos != 0) begin
            add_out(bsc_pkg::PadChar, 1'b1, 1'b0, 1'b0);
            grp_pos = (grp_pos + 1) % glen;
          end
        end
      end
      bits_held  = bits[11:0];
      nbits_held = cnt;
    end
    if (last) begin
      mark_last();
      restart_stream();
    end
  endfunction

  // returns bytes yielded by the gathered group, -1 on an illegal char
  function automatic int decode_group();
    int hi, lo, w, nb, pads, v;
    logic [63:0] acc;
    if (active_base() == bsc_pkg::BASE16) begin
      for (int i = 0; i < (grp_pos >> 1); i++) begin
        hi = value_of(char_grp[2 * i]);
        lo = value_of(char_grp[2 * i + 1]);
        if (hi < 0 || lo < 0) return -1;
        grp_bytes[i] = 8'((hi << 4) | lo);
      end
      return grp_pos >> 1;
    end
    w    = (active_base() == bsc_pkg::BASE32) ? 5 : 6;
    nb   = w;
    acc  = '0;
    pads = 0;
    for (int i = 0; i < 8; i++) begin
      v = 0;
      if (i < grp_pos && char_grp[i] != bsc_pkg::PadChar) begin
        v = value_of(char_grp[i]);
        if (v < 0) return -1;
      end else begin
        pads++;
      end
      acc = (acc << w) | 64'(v);
    end
    for (int i = 0; i < nb; i++) grp_bytes[i] = 8'(acc >> (8 * (nb - 1 - i)));
    return bytes_for_pads(pads);
  endfunction

  function automatic void decode_char(logic [7:0] c, logic last);
    int got;
    if (discard) begin
      if (last) restart_stream();
      return;
    end
    char_grp[grp_pos & 7] = c;
    grp_pos++;
    if (grp_pos < 8 && !last) return;
    got = decode_group();
    if (got < 0) begin
      add_out(8'h00, 1'b0, 1'b1, 1'b1);
      restart_stream();
      discard = !last;
      return;
    end
    for (int i = 0; i < got; i++) add_out(grp_bytes[i], 1'b1, 1'b0, 1'b0);
    grp_pos = 0;
    foreach (char_grp[i]) char_grp[i] = '0;
    if (last) begin
      if (burst_q.size() == 0) add_out(8'h00, 1'b0, 1'b1, 1'b0);
      else mark_last();
      restart_stream();
    end
  endfunction

  function automatic void apply_reg(logic [1:0] idx, logic [1:0] val);
    case (idx)
      bsc_pkg::RegDirection:     cfg_dir  = val[0];
      bsc_pkg::RegBaseSelect:    cfg_base = val;
      bsc_pkg::RegPaddingEnable: cfg_pad  = val[0];
      bsc_pkg::RegAltAlphabet:   cfg_alt  = val[0];
    endcase
    restart_stream();
  endfunction

  function automatic void check_out();
    bsc_pkg::res_t act, exp_r;
    act.data     = m_axis_tdata;
    act.has_data = m_axis_tuser[0];
    act.last     = m_axis_tlast;
    act.bad      = m_axis_tuser[1];
    if (expected_out_q.size() == 0) begin
      err_cnt++;
      if (err_cnt <= 10)
        $display("%0t: unexpected item data %h has_data %b last %b bad %b",
                 $time, act.data, act.has_data, act.last, act.bad);
      return;
    end
    exp_r = expected_out_q.pop_front();
    if (act.data !== exp_r.data || act.has_data !== exp_r.has_data ||
        act.last !== exp_r.last || act.bad !== exp_r.bad) begin
      err_cnt++;
      if (err_cnt <= 10)
        $display("%0t: mismatch exp/act data %h/%h has_data %b/%b last %b/%b bad %b/%b",
                 $time, exp_r.data, act.data, exp_r.has_data, act.has_data,
                 exp_r.last, act.last, exp_r.bad, act.bad);
    end
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(4_000_000);
    $display("status: fail");
    $finish;
  end

  always @(posedge clk_i) begin
    in_fire = 1'b0;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) apply_reg(cfg_index_i, cfg_data_i);
      if (s_axis_tvalid && s_axis_tready) begin
        in_fire = 1'b1;
        n_taken++;
        burst_q.delete();
        if (cfg_dir) decode_char(s_axis_tdata, s_axis_tlast);
        else encode_byte(s_axis_tdata, s_axis_tlast);
        foreach (burst_q[i]) expected_out_q.push_back(burst_q[i]);
      end
      if (m_axis_tvalid && m_axis_tready) check_out();
    end
  end

  function automatic int next_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 20);
  endfunction

  always @(negedge clk_i) begin
    in_item_t nxt;
    if (rst_ni && (!s_axis_tvalid || in_fire)) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (in_items_q.size() != 0) begin
        nxt = in_items_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= nxt.data;
        s_axis_tlast  <= nxt.last;
        gap_left = next_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_req) begin
        hold_req = 1'b0;
        rx_wait  = 300;
      end
      if (rx_wait > 0) begin
        rx_wait--;
        m_axis_tready <= 1'b0;
      end else if (rx_stalls && $urandom_range(0, 99) < 30) begin
        rx_wait = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 25) : $urandom_range(0, 2);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic push_item(logic [7:0] d, logic l);
    in_item_t it;
    it.data = d;
    it.last = l;
    in_items_q.push_back(it);
    n_queued++;
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_item(s[i], i == s.len() - 1);
  endtask

  task automatic drain();
    do @(negedge clk_i); while (n_taken != n_queued || expected_out_q.size() != 0);
    repeat (12) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_mode(logic dir, logic [1:0] base, logic pad, logic alt);
    drain();
    write_reg(bsc_pkg::RegDirection, {1'b0, dir});
    write_reg(bsc_pkg::RegBaseSelect, base);
    write_reg(bsc_pkg::RegPaddingEnable, {1'b0, pad});
    write_reg(bsc_pkg::RegAltAlphabet, {1'b0, alt});
  endtask

  task automatic gen_encode_stream();
    int len, r;
    logic [7:0] b;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 9);
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 9);
      b = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom_range(0, 255));
      push_item(b, i == len - 1);
    end
  endtask

  function automatic logic [7:0] corrupt_char();
    case ($urandom_range(0, 2))
      0: return 8'($urandom_range(0, 255));
      1: return bsc_pkg::PadChar;
      default: return 8'h61 + 8'($urandom_range(0, 25));
    endcase
  endfunction

  task automatic gen_decode_stream();
    string a;
    int mode, groups, m, p, total, bad_at;
    logic [7:0] c;
    a    = alphabet();
    mode = $urandom_range(0, 9);
    if (mode == 9) begin
      total = $urandom_range(1, 12);
      for (int i = 0; i < total; i++) push_item(8'($urandom_range(0, 255)), i == total - 1);
      return;
    end
    groups = ($urandom_range(0, 5) == 0) ? $urandom_range(3, 4) : $urandom_range(0, 2);
    m      = $urandom_range(0, 8);
    p      = (active_base() == bsc_pkg::BASE16 && $urandom_range(0, 3) != 0) ? 0 :
             $urandom_range(0, 8 - m);
    total  = groups * 8 + m + p;
    if (total == 0) begin
      m     = 1;
      total = 1;
    end
    bad_at = (mode >= 7) ? $urandom_range(0, total - 1) : -1;
    for (int i = 0; i < total; i++) begin
      c = (i < groups * 8 + m) ? a[$urandom_range(0, a.len() - 1)] : bsc_pkg::PadChar;
      if (i == bad_at) c = corrupt_char();
      push_item(c, i == total - 1);
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    gaps_on       = 1'b1;
    rx_stalls     = 1'b1;
    restart_stream();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset config: encode, Base64, padded, standard alphabet
    push_item(8'hFF, 1'b0);
    push_item(8'hFB, 1'b1);
    push_item(8'hFF, 1'b1);
    set_mode(1'b0, bsc_pkg::BASE64, 1'b0, 1'b1);
    push_item(8'hFB, 1'b0);
    push_item(8'hFF, 1'b1);
    set_mode(1'b0, bsc_pkg::BASE32, 1'b1, 1'b0);
    push_item(8'h00, 1'b1);
    set_mode(1'b1, bsc_pkg::BASE64, 1'b1, 1'b0);
    push_text("==");
    push_text("A");
    push_text("!AAAAAAAB");
    set_mode(1'b1, 2'd3, 1'b1, 1'b1);
    push_text("-_");
    set_mode(1'b1, bsc_pkg::BASE16, 1'b1, 1'b0);
    push_text("FF0");
    push_text("=A");
    set_mode(1'b1, bsc_pkg::BASE32, 1'b0, 1'b0);
    push_text("me");

    // receiver holds off while the sender keeps offering
    set_mode(1'b0, bsc_pkg::BASE16, 1'b1, 1'b0);
    gaps_on  = 1'b0;
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++) push_item(8'($urandom_range(0, 255)), i == 39);

    drain();
    while (n_queued < 400) begin
      set_mode(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      gaps_on   = $urandom_range(0, 3) != 0;
      rx_stalls = $urandom_range(0, 3) != 0;
      repeat ($urandom_range(1, 4)) begin
        if (cfg_dir) gen_decode_stream();
        else gen_encode_stream();
      end
      drain();
    end

    drain();
    if (err_cnt == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/bsc_pkg.sv
rtl/bsc_step.sv
rtl/base16_32_64_stream_codec_top.sv
dv/tb_base16_32_64_stream_codec_top.sv
